// File: sv/dlr_pkg.sv
// shared types and constants of the dda line rasterizer
// payload structs, register indexes and sequencer states; no dependencies
`default_nettype none

package dlr_pkg;

   // fixed field widths
   localparam int unsigned COORD_W = 6;
   localparam int unsigned COLOR_W = 8;
   localparam int unsigned ADDR_W  = 12;
   localparam int unsigned DIM_W   = 7;
   localparam int unsigned CSR_IDX_W = 2;
   // width*height and y*width+x never exceed 127*127
   localparam int unsigned LIMIT_W = 14;

   // fixed point: 16 fraction bits, quotient holds up to 1.0
   localparam int unsigned FRAC_W = 16;
   localparam int unsigned QUO_W  = FRAC_W + 1;
   localparam int unsigned INC_W  = FRAC_W + 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_PIXELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT  = 2'd1;

   localparam logic [DIM_W-1:0] ROW_PIXELS_RESET = 7'd64;
   localparam logic [DIM_W-1:0] ROW_COUNT_RESET  = 7'd64;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [ADDR_W-1:0]  pixel_address;
      logic               in_image;
      logic [COLOR_W-1:0] out_red;
      logic [COLOR_W-1:0] out_green;
      logic [COLOR_W-1:0] out_blue;
      logic               last_pixel;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DRAW
   } state_type;

endpackage

`default_nettype wire

// File: sv/dda_line_rasterizer.sv
// dda line rasterizer top level: setup, serial divider and pixel stepper
// depends on dlr_pkg for payload structs, register indexes and states
// a line command is taken in the idle state, the serial divider then works through
//   every quotient bit, and the first pixel enters the output register once it is free
// throughput: one pixel per cycle while the output is taken, steps+1 pixels per
//   line, and no new line is taken until the last pixel of a line is registered
// equal endpoints give no pixel and leave the block ready at once
// reset (synchronous, active high) clears the sequencer and output valid and
//   sets the row length and the row count to 64
`default_nettype none

module dda_line_rasterizer #(
   parameter int unsigned COORD_BITS = 6
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  dlr_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output dlr_pkg::rsp_type                  rsp_data,
   input  wire                               csr_write_enable,
   input  wire  [dlr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [dlr_pkg::DIM_W-1:0]         csr_wdata
);

   localparam int unsigned POS_W = COORD_BITS + dlr_pkg::FRAC_W + 2;
   localparam int unsigned REM_W = COORD_BITS + 1;
   localparam int unsigned DCNT_W = $clog2(dlr_pkg::QUO_W);
   localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(dlr_pkg::QUO_W - 1);
   localparam logic signed [dlr_pkg::INC_W-1:0] INC_ONE =
      dlr_pkg::INC_W'(1 << dlr_pkg::FRAC_W);
   localparam logic signed [POS_W-1:0] HALF =
      POS_W'(1 << (dlr_pkg::FRAC_W - 1));

   // registers
   dlr_pkg::state_type state_ff, state_in;
   logic [dlr_pkg::DIM_W-1:0]      width_ff, width_in;
   logic [dlr_pkg::DIM_W-1:0]      height_ff, height_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   dlr_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic [COORD_BITS-1:0]          steps_ff, steps_in;
   logic [COORD_BITS-1:0]          pix_cnt_ff, pix_cnt_in;
   logic [DCNT_W-1:0]              div_cnt_ff, div_cnt_in;
   logic [REM_W-1:0]               rem_ff, rem_in;
   logic [dlr_pkg::QUO_W-1:0]      quo_ff, quo_in;
   logic                           x_major_ff, x_major_in;
   logic                           y_neg_ff, y_neg_in;
   logic signed [dlr_pkg::INC_W-1:0] xinc_ff, xinc_in;
   logic signed [dlr_pkg::INC_W-1:0] yinc_ff, yinc_in;
   logic signed [POS_W-1:0]        xpos_ff, xpos_in;
   logic signed [POS_W-1:0]        ypos_ff, ypos_in;
   logic [dlr_pkg::LIMIT_W-1:0]    limit_ff, limit_in;
   logic [dlr_pkg::COLOR_W-1:0]    red_ff, red_in;
   logic [dlr_pkg::COLOR_W-1:0]    green_ff, green_in;
   logic [dlr_pkg::COLOR_W-1:0]    blue_ff, blue_in;

   // setup terms of the incoming command
   logic [COORD_BITS-1:0] in_sx, in_sy, in_ex, in_ey;
   logic [COORD_BITS-1:0] p_sx, p_sy, p_ex, p_ey;
   logic                  swap, same_point;
   logic [COORD_BITS-1:0] adx, ady;
   logic signed [COORD_BITS:0] dy;

   // divider step
   logic                  quo_bit;
   logic [REM_W-1:0]      rem_sub;
   logic signed [dlr_pkg::INC_W-1:0] minor_inc;

   // pixel terms
   logic signed [POS_W-1:0] xr, yr;
   logic [COORD_BITS-1:0]   px, py;
   logic [dlr_pkg::LIMIT_W-1:0] addr_full;
   logic                    out_free;

   // endpoint order and deltas
   always_comb begin
      in_sx = req_data.start_x[COORD_BITS-1:0];
      in_sy = req_data.start_y[COORD_BITS-1:0];
      in_ex = req_data.end_x[COORD_BITS-1:0];
      in_ey = req_data.end_y[COORD_BITS-1:0];
      same_point = (in_sx == in_ex) && (in_sy == in_ey);
      swap = (in_sx > in_ex) || ((in_sx == in_ex) && (in_sy > in_ey));
      p_sx = swap ? in_ex : in_sx;
      p_sy = swap ? in_ey : in_sy;
      p_ex = swap ? in_sx : in_ex;
      p_ey = swap ? in_sy : in_ey;
      adx = p_ex - p_sx;
      dy = $signed({1'b0, p_ey}) - $signed({1'b0, p_sy});
      ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
   end

   // one restoring division step: minor delta * 2^16 / steps
   always_comb begin
      quo_bit = rem_ff >= REM_W'(steps_ff);
      rem_sub = quo_bit ? (rem_ff - REM_W'(steps_ff)) : rem_ff;
   end

   // rounded pixel and its linear address
   always_comb begin
      xr = xpos_ff + HALF;
      yr = ypos_ff + HALF;
      px = xr[POS_W-1] ? '0 : xr[dlr_pkg::FRAC_W +: COORD_BITS];
      py = yr[POS_W-1] ? '0 : yr[dlr_pkg::FRAC_W +: COORD_BITS];
      addr_full = dlr_pkg::LIMIT_W'(py) * dlr_pkg::LIMIT_W'(width_ff)
                + dlr_pkg::LIMIT_W'(px);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer, configuration and datapath next values
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      steps_in     = steps_ff;
      pix_cnt_in   = pix_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      x_major_in   = x_major_ff;
      y_neg_in     = y_neg_ff;
      xinc_in      = xinc_ff;
      yinc_in      = yinc_ff;
      xpos_in      = xpos_ff;
      ypos_in      = ypos_ff;
      limit_in     = limit_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      minor_inc    = '0;
      req_ready    = 1'b0;

      if (csr_write_enable) begin
         case (csr_index)
            dlr_pkg::CSR_ROW_PIXELS: width_in = csr_wdata;
            dlr_pkg::CSR_ROW_COUNT:  height_in = csr_wdata;
            default: ;
         endcase
      end

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         dlr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               x_major_in = adx >= ady;
               y_neg_in   = dy[COORD_BITS];
               steps_in   = (adx >= ady) ? adx : ady;
               rem_in     = REM_W'((adx >= ady) ? ady : adx);
               quo_in     = '0;
               div_cnt_in = '0;
               pix_cnt_in = '0;
               xpos_in    = POS_W'({p_sx, {dlr_pkg::FRAC_W{1'b0}}});
               ypos_in    = POS_W'({p_sy, {dlr_pkg::FRAC_W{1'b0}}});
               limit_in   = dlr_pkg::LIMIT_W'(width_ff) * dlr_pkg::LIMIT_W'(height_ff);
               red_in     = req_data.red;
               green_in   = req_data.green;
               blue_in    = req_data.blue;
               if (!same_point) begin
                  state_in = dlr_pkg::ST_DIV;
               end
            end
         end
         dlr_pkg::ST_DIV: begin
            rem_in     = {rem_sub[REM_W-2:0], 1'b0};
            quo_in     = {quo_ff[dlr_pkg::QUO_W-2:0], quo_bit};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               minor_inc = dlr_pkg::INC_W'(quo_in);
               if (x_major_ff) begin
                  xinc_in = INC_ONE;
                  yinc_in = y_neg_ff ? -minor_inc : minor_inc;
               end else begin
                  xinc_in = minor_inc;
                  yinc_in = y_neg_ff ? -INC_ONE : INC_ONE;
               end
               state_in = dlr_pkg::ST_DRAW;
            end
         end
         dlr_pkg::ST_DRAW: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.pixel_x       = dlr_pkg::COORD_W'(px);
               rsp_data_in.pixel_y       = dlr_pkg::COORD_W'(py);
               rsp_data_in.pixel_address = addr_full[dlr_pkg::ADDR_W-1:0];
               rsp_data_in.in_image      = addr_full < limit_ff;
               rsp_data_in.out_red       = red_ff;
               rsp_data_in.out_green     = green_ff;
               rsp_data_in.out_blue      = blue_ff;
               rsp_data_in.last_pixel    = pix_cnt_ff == steps_ff;
               xpos_in    = xpos_ff + POS_W'(xinc_ff);
               ypos_in    = ypos_ff + POS_W'(yinc_ff);
               pix_cnt_in = pix_cnt_ff + 1'b1;
               if (pix_cnt_ff == steps_ff) begin
                  state_in = dlr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = dlr_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlr_pkg::ST_IDLE;
         width_ff     <= dlr_pkg::ROW_PIXELS_RESET;
         height_ff    <= dlr_pkg::ROW_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      steps_ff    <= steps_in;
      pix_cnt_ff  <= pix_cnt_in;
      div_cnt_ff  <= div_cnt_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      x_major_ff  <= x_major_in;
      y_neg_ff    <= y_neg_in;
      xinc_ff     <= xinc_in;
      yinc_ff     <= yinc_in;
      xpos_ff     <= xpos_in;
      ypos_ff     <= ypos_in;
      limit_ff    <= limit_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: sv/dlr_checker.sv
// port-level checks of the dda line rasterizer, bound to the top level
// depends on dlr_pkg for the payload structs
`default_nettype none

module dlr_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_ready,
   input wire dlr_pkg::req_type  req_data,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wire dlr_pkg::rsp_type  rsp_data
);

   // a stalled input item stays offered
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("input item dropped or changed while stalled");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped or changed while stalled");

   // no new line is taken while one is still being drawn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_pixel |-> !req_ready)
      else $error("input ready in the middle of a line");

   // a taken pixel that is not the last is followed at once by the next
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_pixel |=> rsp_valid)
      else $error("gap between pixels of one line");

endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the dda line rasterizer
// needs dlr_pkg and dda_line_rasterizer; predicts every pixel write on its own
`timescale 1ns / 100ps

module testbench;

   // register indexes with no register behind them, writes must be ignored
   localparam logic [dlr_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [dlr_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam int PHASES          = 7;
   localparam int LINES_PER_PHASE = 52;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int MAX_LINE_PIXELS = 64;

   // expected pixel writes of accepted line commands, oldest first
   class line_pixel_board;
      logic [dlr_pkg::DIM_W-1:0] row_pixels;
      logic [dlr_pkg::DIM_W-1:0] row_count;
      dlr_pkg::rsp_type          pending_pixels[$];
      int unsigned               mismatches;

      function new();
         row_pixels = dlr_pkg::ROW_PIXELS_RESET;
         row_count  = dlr_pkg::ROW_COUNT_RESET;
         mismatches = 0;
      endfunction

      function void set_register(logic [dlr_pkg::CSR_IDX_W-1:0] index,
                                 logic [dlr_pkg::DIM_W-1:0] value);
         case (index)
            dlr_pkg::CSR_ROW_PIXELS: begin
               row_pixels = value;
            end
            dlr_pkg::CSR_ROW_COUNT: begin
               row_count = value;
            end
            default: begin
            end
         endcase
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      // q16 increment, quotient truncated toward zero
      function longint q16_step(longint delta, longint steps);
         longint mag;
         longint quo;
         mag = (delta < 0) ? -delta : delta;
         quo = (mag * 65536) / steps;
         return (delta < 0) ? -quo : quo;
      endfunction

      // round half up from q16 position, clamped at zero
      function longint to_pixel(longint pos);
         longint r;
         r = pos + 32768;
         if (r < 0) begin
            r = 0;
         end
         return r >> 16;
      endfunction

      // walk the line and queue one pixel write per step
      function void plot_line(dlr_pkg::req_type cmd);
         longint  sx, sy, ex, ey, tmp;
         longint  dx, dy, adx, ady, steps;
         longint  xinc, yinc, xpos, ypos;
         longint  px, py, addr, limit;
         longint  i;
         dlr_pkg::rsp_type pix;
         sx = longint'(cmd.start_x);
         sy = longint'(cmd.start_y);
         ex = longint'(cmd.end_x);
         ey = longint'(cmd.end_y);
         if (sx == ex && sy == ey) begin
            return;
         end
         // order endpoints by x, then y
         if (sx > ex || (sx == ex && sy > ey)) begin
            tmp = sx; sx = ex; ex = tmp;
            tmp = sy; sy = ey; ey = tmp;
         end
         dx    = ex - sx;
         dy    = ey - sy;
         adx   = (dx < 0) ? -dx : dx;
         ady   = (dy < 0) ? -dy : dy;
         steps = (adx > ady) ? adx : ady;
         xinc  = q16_step(dx, steps);
         yinc  = q16_step(dy, steps);
         xpos  = sx * 65536;
         ypos  = sy * 65536;
         limit = longint'(row_pixels) * longint'(row_count);
         for (i = 0; i <= steps && i < MAX_LINE_PIXELS; i++) begin
            px   = to_pixel(xpos);
            py   = to_pixel(ypos);
            addr = py * longint'(row_pixels) + px;
            pix.pixel_x       = px[dlr_pkg::COORD_W-1:0];
            pix.pixel_y       = py[dlr_pkg::COORD_W-1:0];
            pix.pixel_address = addr[dlr_pkg::ADDR_W-1:0];
            pix.in_image      = (addr < limit);
            pix.out_red       = cmd.red;
            pix.out_green     = cmd.green;
            pix.out_blue      = cmd.blue;
            pix.last_pixel    = (i == steps);
            pending_pixels.push_back(pix);
            xpos += xinc;
            ypos += yinc;
         end
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task compare_field(string name, int unsigned got, int unsigned want);
         if (got != want) begin
            report($sformatf("%s got %0d, want %0d", name, got, want));
         end
      endtask

      // compare an accepted pixel write with the oldest expected one
      task check_pixel(dlr_pkg::rsp_type got);
         dlr_pkg::rsp_type want;
         if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y));
            return;
         end
         want = pending_pixels.pop_front();
         compare_field("pixel_x", 32'(got.pixel_x), 32'(want.pixel_x));
         compare_field("pixel_y", 32'(got.pixel_y), 32'(want.pixel_y));
         compare_field("pixel_address", 32'(got.pixel_address), 32'(want.pixel_address));
         compare_field("in_image", 32'(got.in_image), 32'(want.in_image));
         compare_field("out_red", 32'(got.out_red), 32'(want.out_red));
         compare_field("out_green", 32'(got.out_green), 32'(want.out_green));
         compare_field("out_blue", 32'(got.out_blue), 32'(want.out_blue));
         compare_field("last_pixel", 32'(got.last_pixel), 32'(want.last_pixel));
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   dlr_pkg::req_type              req_data;
   logic                          rsp_valid;
   logic                          rsp_ready;
   dlr_pkg::rsp_type              rsp_data;
   logic                          csr_write_enable;
   logic [dlr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [dlr_pkg::DIM_W-1:0]     csr_wdata;

   line_pixel_board board;
   bit              calm;

   dda_line_rasterizer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   // result side: random stall bursts, always ready once calm
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end
      end
   end

   // check every accepted pixel write
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_pixel(rsp_data);
      end
   end

   // one register write, entered and left at a falling edge
   task write_register(logic [dlr_pkg::CSR_IDX_W-1:0] index,
                       logic [dlr_pkg::DIM_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_wdata        <= value;
      @(posedge clock);
      board.set_register(index, value);
      @(negedge clock);
   endtask

   // offer one line command, with a random gap in front unless calm
   task send_line(dlr_pkg::req_type cmd);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do begin
         @(posedge clock);
      end while (!req_ready);
      board.plot_line(cmd);
      @(negedge clock);
   endtask

   // hold off new lines until every expected pixel has come out
   task drain_pixels();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (board.pending() != 0) begin
         board.report($sformatf("%0d pixels never arrived", board.pending()));
         board.pending_pixels.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function dlr_pkg::req_type make_line(int sx, int sy, int ex, int ey,
                                        int r, int g, int b);
      dlr_pkg::req_type cmd;
      cmd.start_x = dlr_pkg::COORD_W'(sx);
      cmd.start_y = dlr_pkg::COORD_W'(sy);
      cmd.end_x   = dlr_pkg::COORD_W'(ex);
      cmd.end_y   = dlr_pkg::COORD_W'(ey);
      cmd.red     = dlr_pkg::COLOR_W'(r);
      cmd.green   = dlr_pkg::COLOR_W'(g);
      cmd.blue    = dlr_pkg::COLOR_W'(b);
      return cmd;
   endfunction

   function int clamp_coord(int v);
      if (v < 0) begin
         return 0;
      end
      if (v > 63) begin
         return 63;
      end
      return v;
   endfunction

   // random line: mostly general, with flat, upright, diagonal, short and dot lines mixed in
   function dlr_pkg::req_type random_line();
      dlr_pkg::req_type cmd;
      int               len;
      int               lo;
      cmd.start_x = dlr_pkg::COORD_W'($urandom_range(0, 63));
      cmd.start_y = dlr_pkg::COORD_W'($urandom_range(0, 63));
      cmd.end_x   = dlr_pkg::COORD_W'($urandom_range(0, 63));
      cmd.end_y   = dlr_pkg::COORD_W'($urandom_range(0, 63));
      cmd.red     = dlr_pkg::COLOR_W'($urandom_range(0, 255));
      cmd.green   = dlr_pkg::COLOR_W'($urandom_range(0, 255));
      cmd.blue    = dlr_pkg::COLOR_W'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0: begin
            cmd.end_x = cmd.start_x;
            cmd.end_y = cmd.start_y;
         end
         1: begin
            cmd.end_y = cmd.start_y;
         end
         2: begin
            cmd.end_x = cmd.start_x;
         end
         3: begin
            len = int'($urandom_range(1, 63));
            lo  = int'($urandom_range(0, 63 - len));
            cmd.start_x = dlr_pkg::COORD_W'(lo);
            cmd.end_x   = dlr_pkg::COORD_W'(lo + len);
            lo  = int'($urandom_range(0, 63 - len));
            if ($urandom_range(0, 1) == 1) begin
               cmd.start_y = dlr_pkg::COORD_W'(lo);
               cmd.end_y   = dlr_pkg::COORD_W'(lo + len);
            end else begin
               cmd.start_y = dlr_pkg::COORD_W'(lo + len);
               cmd.end_y   = dlr_pkg::COORD_W'(lo);
            end
         end
         4: begin
            cmd.end_x = dlr_pkg::COORD_W'(clamp_coord(int'(cmd.start_x)
                                          + int'($urandom_range(0, 6)) - 3));
            cmd.end_y = dlr_pkg::COORD_W'(clamp_coord(int'(cmd.start_y)
                                          + int'($urandom_range(0, 6)) - 3));
         end
         default: begin
         end
      endcase
      return cmd;
   endfunction

   // corners, flat and upright lines, swapped ends, dots and rounding ties
   task run_directed();
      send_line(make_line(0, 0, 63, 63, 255, 0, 255));
      send_line(make_line(63, 63, 0, 0, 0, 255, 0));
      send_line(make_line(0, 63, 63, 0, 255, 255, 255));
      send_line(make_line(63, 0, 0, 63, 0, 0, 0));
      send_line(make_line(5, 5, 5, 5, 1, 2, 3));
      send_line(make_line(0, 0, 0, 0, 255, 255, 255));
      send_line(make_line(63, 63, 63, 63, 0, 0, 0));
      send_line(make_line(0, 10, 63, 10, 170, 85, 170));
      send_line(make_line(63, 20, 0, 20, 85, 170, 85));
      send_line(make_line(10, 0, 10, 63, 255, 0, 0));
      send_line(make_line(12, 63, 12, 0, 0, 255, 0));
      send_line(make_line(3, 0, 7, 63, 0, 0, 255));
      send_line(make_line(0, 2, 63, 5, 128, 64, 32));
      send_line(make_line(0, 0, 2, 1, 16, 8, 4));
      send_line(make_line(2, 1, 0, 0, 4, 8, 16));
      send_line(make_line(0, 0, 1, 0, 255, 1, 127));
      send_line(make_line(0, 1, 1, 0, 127, 254, 1));
      send_line(make_line(40, 7, 1, 60, 33, 66, 99));
      send_line(make_line(0, 0, 3, 2, 200, 100, 50));
      send_line(make_line(21, 42, 42, 21, 170, 85, 255));
   endtask

   // image size for each random phase: largest, smallest, zero width and height, odd sizes
   task configure_phase(int phase);
      case (phase)
         1: begin
            write_register(dlr_pkg::CSR_ROW_PIXELS, 7'd127);
            write_register(dlr_pkg::CSR_ROW_COUNT, 7'd127);
            write_register(CSR_SPARE_A, dlr_pkg::DIM_W'($urandom_range(0, 127)));
            write_register(CSR_SPARE_B, dlr_pkg::DIM_W'($urandom_range(0, 127)));
         end
         2: begin
            write_register(dlr_pkg::CSR_ROW_PIXELS, 7'd1);
            write_register(dlr_pkg::CSR_ROW_COUNT, 7'd1);
         end
         3: begin
            write_register(dlr_pkg::CSR_ROW_PIXELS, 7'd0);
            write_register(dlr_pkg::CSR_ROW_COUNT, 7'd64);
         end
         4: begin
            write_register(dlr_pkg::CSR_ROW_PIXELS, 7'd37);
            write_register(dlr_pkg::CSR_ROW_COUNT, 7'd0);
         end
         5: begin
            write_register(dlr_pkg::CSR_ROW_PIXELS, 7'd10);
            write_register(dlr_pkg::CSR_ROW_COUNT, 7'd5);
            write_register(CSR_SPARE_B, dlr_pkg::DIM_W'($urandom_range(0, 127)));
         end
         6: begin
            write_register(dlr_pkg::CSR_ROW_PIXELS, dlr_pkg::DIM_W'($urandom_range(1, 127)));
            write_register(dlr_pkg::CSR_ROW_COUNT, dlr_pkg::DIM_W'($urandom_range(1, 127)));
         end
         default: begin
            write_register(dlr_pkg::CSR_ROW_PIXELS, 7'd64);
            write_register(dlr_pkg::CSR_ROW_COUNT, 7'd64);
         end
      endcase
      csr_write_enable <= 1'b0;
   endtask

   // main sequence
   initial begin
      int phase;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      calm             = 1'b0;
      board            = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      drain_pixels();

      for (phase = 1; phase <= PHASES; phase++) begin
         configure_phase(phase);
         if (phase == PHASES) begin
            calm = 1'b1;
         end
         repeat (LINES_PER_PHASE) send_line(random_line());
         drain_pixels();
      end

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: dda_line_rasterizer.f
sv/dlr_pkg.sv
sv/dda_line_rasterizer.sv
sv/dlr_checker.sv
tb/testbench.sv
